/* rtl/imt_pkg.sv */
// Shared constants, types and controller/datapath command structs for the Ising trial unit.
package imt_pkg;

   localparam int MAX_SIDE = 64;
   localparam int ROW_W = $clog2(MAX_SIDE);
   localparam int SIDE_W = 7;
   localparam int LEVEL_W = 32;
   localparam int DE_W = 5;
   localparam int ENERGY_W = 15;
   localparam int MAG_W = 14;
   localparam int COUNT_W = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam int RESET_SIDE = 64;
   localparam int RESET_SIDE_USE = (RESET_SIDE < MAX_SIDE) ? RESET_SIDE : MAX_SIDE;

   typedef logic [ROW_W-1:0] row_type;
   typedef logic [MAX_SIDE-1:0] lattice_row_type;
   typedef logic [1:0] mode_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam mode_type MODE_WRITE = 2'd0;
   localparam mode_type MODE_TRIAL = 2'd1;
   localparam mode_type MODE_RESCAN = 2'd2;

   localparam csr_index_type CSR_LATTICE_SIDE = 2'd0;
   localparam csr_index_type CSR_ACCEPT_FOUR = 2'd1;
   localparam csr_index_type CSR_ACCEPT_EIGHT = 2'd2;

   localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(RESET_SIDE);
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(4096);
   localparam logic signed [ENERGY_W-1:0] ENERGY_RESET =
      ENERGY_W'(-2 * RESET_SIDE_USE * RESET_SIDE_USE);
   localparam logic signed [MAG_W-1:0] MAG_RESET = MAG_W'(RESET_SIDE_USE * RESET_SIDE_USE);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE_SPIN,
      ST_TRIAL_UP,
      ST_TRIAL_DOWN,
      ST_TRIAL_DECIDE,
      ST_SCAN_PREV,
      ST_SCAN_LOAD,
      ST_SCAN_COL,
      ST_SCAN_COMMIT,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      RD_REQ_ROW,
      RD_LAST_ROW,
      RD_UP_ROW,
      RD_DOWN_ROW,
      RD_SCAN_ROW,
      RD_NEXT_ROW
   } rd_sel_type;

   typedef struct packed {
      rd_sel_type rd_sel;
      logic load_item;
      logic cap_cur;
      logic cap_up;
      logic trial_commit;
      logic spin_write;
      logic scan_init;
      logic scan_step;
      logic scan_commit;
      logic clear_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic req_bad;
      logic clear_last;
      logic col_last;
      logic row_last;
   } status_type;

endpackage

/* rtl/imt_channels.sv */
// Valid/ready channel interfaces for request items and result items.
interface imt_req_if;
   import imt_pkg::*;

   logic valid;
   logic ready;
   mode_type mode;
   row_type row;
   row_type col;
   logic spin_up;
   logic [LEVEL_W-1:0] uniform;
   logic sweep_start;

   modport source (output valid, mode, row, col, spin_up, uniform, sweep_start,
                   input ready);
   modport sink (input valid, mode, row, col, spin_up, uniform, sweep_start,
                 output ready);
endinterface

interface imt_rsp_if;
   import imt_pkg::*;

   logic valid;
   logic ready;
   logic accepted;
   logic signed [DE_W-1:0] delta_energy;
   logic signed [ENERGY_W-1:0] energy;
   logic signed [MAG_W-1:0] magnetization;
   logic [COUNT_W-1:0] accepted_count;
   logic bad_site;

   modport source (output valid, accepted, delta_energy, energy, magnetization,
                   accepted_count, bad_site, input ready);
   modport sink (input valid, accepted, delta_energy, energy, magnetization,
                 accepted_count, bad_site, output ready);
endinterface

/* rtl/imt_ctrl.sv */
// Sequencer for spin writes, Metropolis trials, rescans and the post-reset lattice fill.
module imt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  imt_pkg::mode_type  req_mode,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  imt_pkg::status_type status,
   output imt_pkg::cmd_type   cmd
);
   import imt_pkg::*;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.rd_sel = RD_REQ_ROW;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               case (req_mode)
                  MODE_WRITE: state_in = status.req_bad ? ST_FINISH : ST_WRITE_SPIN;
                  MODE_TRIAL: state_in = status.req_bad ? ST_FINISH : ST_TRIAL_UP;
                  MODE_RESCAN: begin
                     cmd.rd_sel = RD_LAST_ROW;
                     cmd.scan_init = 1'b1;
                     state_in = ST_SCAN_PREV;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_WRITE_SPIN: begin
            cmd.spin_write = 1'b1;
            state_in = ST_FINISH;
         end
         ST_TRIAL_UP: begin
            cmd.cap_cur = 1'b1;
            cmd.rd_sel = RD_UP_ROW;
            state_in = ST_TRIAL_DOWN;
         end
         ST_TRIAL_DOWN: begin
            cmd.cap_up = 1'b1;
            cmd.rd_sel = RD_DOWN_ROW;
            state_in = ST_TRIAL_DECIDE;
         end
         ST_TRIAL_DECIDE: begin
            cmd.trial_commit = 1'b1;
            state_in = ST_FINISH;
         end
         ST_SCAN_PREV: begin
            cmd.cap_up = 1'b1;
            cmd.rd_sel = RD_SCAN_ROW;
            state_in = ST_SCAN_LOAD;
         end
         ST_SCAN_LOAD: begin
            cmd.cap_cur = 1'b1;
            state_in = ST_SCAN_COL;
         end
         ST_SCAN_COL: begin
            cmd.scan_step = 1'b1;
            cmd.rd_sel = RD_NEXT_ROW;
            if (status.col_last) begin
               state_in = status.row_last ? ST_SCAN_COMMIT : ST_SCAN_LOAD;
            end
         end
         ST_SCAN_COMMIT: begin
            cmd.scan_commit = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      if (cmd.load_out) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/imt_datapath.sv */
// Lattice row memory, running totals, trial arithmetic, rescan accumulators and result register.
module imt_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  imt_pkg::csr_index_type         csr_index,
   input  logic [imt_pkg::CSR_DATA_W-1:0] csr_wr_data,
   input  imt_pkg::mode_type              req_mode,
   input  imt_pkg::row_type               req_row,
   input  imt_pkg::row_type               req_col,
   input  logic                           req_spin_up,
   input  logic [imt_pkg::LEVEL_W-1:0]    req_uniform,
   input  logic                           req_sweep_start,
   input  imt_pkg::cmd_type               cmd,
   output imt_pkg::status_type            status,
   output logic                           rsp_accepted,
   output logic signed [imt_pkg::DE_W-1:0]     rsp_delta_energy,
   output logic signed [imt_pkg::ENERGY_W-1:0] rsp_energy,
   output logic signed [imt_pkg::MAG_W-1:0]    rsp_magnetization,
   output logic [imt_pkg::COUNT_W-1:0]    rsp_accepted_count,
   output logic                           rsp_bad_site
);
   import imt_pkg::*;

   // configuration
   logic [SIDE_W-1:0] side_ff;
   logic [LEVEL_W-1:0] level_four_ff, level_eight_ff;

   // lattice, one row per word
   lattice_row_type lattice_mem_ff [MAX_SIDE];
   lattice_row_type rd_data_ff;
   lattice_row_type cur_row_ff, up_row_ff;

   // item
   row_type row_ff, col_ff;
   logic spin_ff;
   logic [LEVEL_W-1:0] uniform_ff;
   logic acc_ff, bad_ff;
   logic signed [DE_W-1:0] de_ff;

   // totals and rescan
   logic signed [ENERGY_W-1:0] energy_ff, e_acc_ff;
   logic signed [MAG_W-1:0] mag_ff, m_acc_ff;
   logic [COUNT_W-1:0] count_ff;
   row_type scan_row_ff, scan_col_ff;

   // result register
   logic out_acc_ff, out_bad_ff;
   logic signed [DE_W-1:0] out_de_ff;
   logic signed [ENERGY_W-1:0] out_energy_ff;
   logic signed [MAG_W-1:0] out_mag_ff;
   logic [COUNT_W-1:0] out_count_ff;

   logic [SIDE_W-1:0] side_use;
   row_type side_max, up_row, down_row, col_left, col_right, scan_left, rd_addr, wr_addr;
   lattice_row_type bit_mask, wr_data;
   logic wr_en;
   logic sp, nb_left, nb_right, nb_up, nb_down;
   logic [2:0] same_count;
   logic signed [DE_W-1:0] trial_de;
   logic trial_take;
   logic s_sp, s_ne_left, s_ne_up;
   logic signed [2:0] scan_de;

   // side clamped to 2..MAX_SIDE
   always_comb begin
      if (side_ff < SIDE_W'(2)) side_use = SIDE_W'(2);
      else if (side_ff > SIDE_W'(MAX_SIDE)) side_use = SIDE_W'(MAX_SIDE);
      else side_use = side_ff;
      side_max = ROW_W'(side_use - 1'b1);
   end

   assign status.req_bad = (SIDE_W'(req_row) >= side_use) || (SIDE_W'(req_col) >= side_use);
   assign status.clear_last = (scan_row_ff == ROW_W'(MAX_SIDE - 1));
   assign status.col_last = (scan_col_ff == side_max);
   assign status.row_last = (scan_row_ff == side_max);

   // periodic neighbors
   assign up_row = (row_ff == '0) ? side_max : row_ff - 1'b1;
   assign down_row = (row_ff == side_max) ? '0 : row_ff + 1'b1;
   assign col_left = (col_ff == '0) ? side_max : col_ff - 1'b1;
   assign col_right = (col_ff == side_max) ? '0 : col_ff + 1'b1;
   assign scan_left = (scan_col_ff == '0) ? side_max : scan_col_ff - 1'b1;

   always_comb begin
      case (cmd.rd_sel)
         RD_REQ_ROW:  rd_addr = req_row;
         RD_LAST_ROW: rd_addr = side_max;
         RD_UP_ROW:   rd_addr = up_row;
         RD_DOWN_ROW: rd_addr = down_row;
         RD_SCAN_ROW: rd_addr = scan_row_ff;
         RD_NEXT_ROW: rd_addr = scan_row_ff + 1'b1;
         default:     rd_addr = req_row;
      endcase
   end

   // trial: down row arrives in rd_data_ff during the decide cycle
   always_comb begin
      sp = cur_row_ff[col_ff];
      nb_left = cur_row_ff[col_left];
      nb_right = cur_row_ff[col_right];
      nb_up = up_row_ff[col_ff];
      nb_down = rd_data_ff[col_ff];
      same_count = 3'(nb_left ~^ sp) + 3'(nb_right ~^ sp) + 3'(nb_up ~^ sp)
                 + 3'(nb_down ~^ sp);
      case (same_count)
         3'd0: begin
            trial_de = -DE_W'(8);
            trial_take = 1'b1;
         end
         3'd1: begin
            trial_de = -DE_W'(4);
            trial_take = 1'b1;
         end
         3'd2: begin
            trial_de = '0;
            trial_take = 1'b1;
         end
         3'd3: begin
            trial_de = DE_W'(4);
            trial_take = (uniform_ff <= level_four_ff);
         end
         default: begin
            trial_de = DE_W'(8);
            trial_take = (uniform_ff <= level_eight_ff);
         end
      endcase
   end

   // rescan: bond to the left and bond upward per site
   always_comb begin
      s_sp = cur_row_ff[scan_col_ff];
      s_ne_left = s_sp ^ cur_row_ff[scan_left];
      s_ne_up = s_sp ^ up_row_ff[scan_col_ff];
      case ({s_ne_left, s_ne_up})
         2'b00:   scan_de = -3'sd2;
         2'b11:   scan_de = 3'sd2;
         default: scan_de = '0;
      endcase
   end

   // memory write side
   always_comb begin
      bit_mask = lattice_row_type'(1) << col_ff;
      wr_en = cmd.clear_step || cmd.spin_write || (cmd.trial_commit && trial_take);
      wr_addr = cmd.clear_step ? scan_row_ff : row_ff;
      if (cmd.clear_step) wr_data = '1;
      else if (cmd.spin_write) wr_data = (rd_data_ff & ~bit_mask) | (spin_ff ? bit_mask : '0);
      else wr_data = cur_row_ff ^ bit_mask;
   end

   always_ff @(posedge clock) begin
      if (wr_en) lattice_mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= lattice_mem_ff[rd_addr];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SIDE_RESET;
         level_four_ff <= '0;
         level_eight_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LATTICE_SIDE: side_ff <= csr_wr_data[SIDE_W-1:0];
            CSR_ACCEPT_FOUR:  level_four_ff <= csr_wr_data[LEVEL_W-1:0];
            CSR_ACCEPT_EIGHT: level_eight_ff <= csr_wr_data[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // totals and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff <= ENERGY_RESET;
         mag_ff <= MAG_RESET;
         count_ff <= '0;
         scan_row_ff <= '0;
      end else begin
         if (cmd.load_item && req_mode == MODE_TRIAL && req_sweep_start) count_ff <= '0;
         if (cmd.trial_commit && trial_take) begin
            energy_ff <= energy_ff + ENERGY_W'(trial_de);
            mag_ff <= sp ? mag_ff - MAG_W'(2) : mag_ff + MAG_W'(2);
            if (count_ff < COUNT_LIMIT) count_ff <= count_ff + 1'b1;
         end
         if (cmd.scan_commit) begin
            energy_ff <= e_acc_ff;
            mag_ff <= m_acc_ff;
         end
         if (cmd.clear_step) scan_row_ff <= scan_row_ff + 1'b1;
         if (cmd.scan_init) scan_row_ff <= '0;
         if (cmd.scan_step && status.col_last) scan_row_ff <= scan_row_ff + 1'b1;
      end
   end

   // item and working registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         row_ff <= req_row;
         col_ff <= req_col;
         spin_ff <= req_spin_up;
         uniform_ff <= req_uniform;
         acc_ff <= 1'b0;
         de_ff <= '0;
         bad_ff <= (req_mode == MODE_WRITE || req_mode == MODE_TRIAL) && status.req_bad;
      end
      if (cmd.trial_commit) begin
         acc_ff <= trial_take;
         de_ff <= trial_de;
      end
      if (cmd.cap_cur) cur_row_ff <= rd_data_ff;
      if (cmd.cap_up) up_row_ff <= rd_data_ff;
      if (cmd.scan_init) begin
         e_acc_ff <= '0;
         m_acc_ff <= '0;
         scan_col_ff <= '0;
      end
      if (cmd.scan_step) begin
         e_acc_ff <= e_acc_ff + ENERGY_W'(scan_de);
         m_acc_ff <= s_sp ? m_acc_ff + 1'b1 : m_acc_ff - 1'b1;
         if (status.col_last) begin
            scan_col_ff <= '0;
            up_row_ff <= cur_row_ff;
         end else begin
            scan_col_ff <= scan_col_ff + 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_acc_ff <= acc_ff;
         out_de_ff <= de_ff;
         out_energy_ff <= energy_ff;
         out_mag_ff <= mag_ff;
         out_count_ff <= count_ff;
         out_bad_ff <= bad_ff;
      end
   end

   assign rsp_accepted = out_acc_ff;
   assign rsp_delta_energy = out_de_ff;
   assign rsp_energy = out_energy_ff;
   assign rsp_magnetization = out_mag_ff;
   assign rsp_accepted_count = out_count_ff;
   assign rsp_bad_site = out_bad_ff;

endmodule

/* rtl/ising_metropolis_trial_unit.sv */
// Top level of the 2D Ising Metropolis trial unit: controller, datapath and channel wiring.
// A spin write reads its row and writes it back; a trial reads the site's row, the row above
// and the row below, then decides; a rescan walks the lattice row by row; a bad site or the
// unused mode goes straight to finish. One item at a time; a waiting result does not hold
// back the next item's work, only its move into the result reg.
// Reset (synchronous): totals return to the full-up lattice values, the count clears, and a
// fill pass writes all spins up, one row per cycle, with no item taken.
module ising_metropolis_trial_unit (
   input  logic                           clock,
   input  logic                           reset,
   imt_req_if.sink                        req_chan,
   imt_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  imt_pkg::csr_index_type         csr_index,
   input  logic [imt_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import imt_pkg::*;

   cmd_type cmd;
   status_type status;

   // Sequencer: one state per memory access of a trial; a rescan walks the lattice
   // row by row, one site per cycle within a row, keeping the previous row for the upward bonds.
   imt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Lattice memory (one 64-bit row per word), totals, config and result register.
   imt_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .req_mode           (req_chan.mode),
      .req_row            (req_chan.row),
      .req_col            (req_chan.col),
      .req_spin_up        (req_chan.spin_up),
      .req_uniform        (req_chan.uniform),
      .req_sweep_start    (req_chan.sweep_start),
      .cmd                (cmd),
      .status             (status),
      .rsp_accepted       (rsp_chan.accepted),
      .rsp_delta_energy   (rsp_chan.delta_energy),
      .rsp_energy         (rsp_chan.energy),
      .rsp_magnetization  (rsp_chan.magnetization),
      .rsp_accepted_count (rsp_chan.accepted_count),
      .rsp_bad_site       (rsp_chan.bad_site)
   );

endmodule

/* verif/tb_ising_metropolis_trial_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the Ising Metropolis trial unit: scripted items, then random phases.
module tb_ising_metropolis_trial_unit;
   import imt_pkg::*;

   // mode 3 is unused by the block: it only reports the running totals
   localparam mode_type MODE_IDLE_OP = 2'd3;
   localparam int COUNT_CAP = 4096;
   // a rescan walks every site, so sides above this see at most a phase's opening rescan
   localparam int SMALL_SIDE = 16;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

   typedef struct packed {
      mode_type           mode;
      row_type            row;
      row_type            col;
      logic               spin_up;
      logic [LEVEL_W-1:0] uniform;
      logic               sweep_start;
   } trial_req_type;

   typedef struct packed {
      logic                       accepted;
      logic signed [DE_W-1:0]     delta_energy;
      logic signed [ENERGY_W-1:0] energy;
      logic signed [MAG_W-1:0]    magnetization;
      logic [COUNT_W-1:0]         accepted_count;
      logic                       bad_site;
   } trial_rsp_type;

   // one line of the scripted opening: either a register write or an item,
   // with the outcome typed in where it is obvious
   typedef struct packed {
      logic                  is_csr;
      csr_index_type         csr_sel;
      logic [CSR_DATA_W-1:0] csr_val;
      trial_req_type         op;
      logic                  typed;
      trial_rsp_type         outcome;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   imt_req_if req_chan();
   imt_rsp_if rsp_chan();

   ising_metropolis_trial_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Lattice predictor: own copy of spins, totals, flip tally and registers
   // ---------------------------------------------------------------------
   bit                 grid_spin [MAX_SIDE][MAX_SIDE];   // 1 is spin up
   int                 grid_energy;
   int                 grid_mag;
   int                 flip_tally;
   int                 side_setting;
   logic [LEVEL_W-1:0] thresh4;
   logic [LEVEL_W-1:0] thresh8;

   // outcomes of accepted items, oldest first
   trial_rsp_type trial_outcomes [$];

   int mismatches    = 0;
   int results_seen  = 0;
   int items_sent    = 0;
   int trials_sent   = 0;
   int flips_seen    = 0;
   int rescans_sent  = 0;
   int bad_seen      = 0;
   int settings_used = 0;
   // chance in percent of an idle burst on either side; zero near the end
   int idle_pct      = 0;
   int stall_left    = 0;

   // register value clamped to 2..MAX_SIDE
   function automatic int effective_side();
      if (side_setting < 2) return 2;
      if (side_setting > MAX_SIDE) return MAX_SIDE;
      return side_setting;
   endfunction

   function automatic int spin_val(int r, int c);
      return grid_spin[r][c] ? 1 : -1;
   endfunction

   // apply one item to the predicted lattice, return the result it must give
   function automatic trial_rsp_type lattice_step(trial_req_type op);
      trial_rsp_type o;
      int s, r, c, i, j, sp, nsum, de;
      bit bad, take;
      s = effective_side();
      r = int'(op.row);
      c = int'(op.col);
      bad = (r >= s) || (c >= s);
      o = '0;
      de = 0;
      take = 1'b0;
      case (op.mode)
         MODE_WRITE: begin
            // totals stay stale until a rescan
            if (bad) o.bad_site = 1'b1;
            else grid_spin[r][c] = op.spin_up;
         end
         MODE_TRIAL: begin
            // sweep start clears the tally even for an off-lattice site
            if (op.sweep_start) flip_tally = 0;
            if (bad) begin
               o.bad_site = 1'b1;
            end else begin
               sp = spin_val(r, c);
               nsum = spin_val(r, (c + s - 1) % s) + spin_val((r + s - 1) % s, c)
                    + spin_val(r, (c + 1) % s) + spin_val((r + 1) % s, c);
               de = 2 * sp * nsum;
               // downhill or flat always flips; uphill compares the draw
               if (de <= 0) take = 1'b1;
               else if (de == 4) take = (op.uniform <= thresh4);
               else take = (op.uniform <= thresh8);
               if (take) begin
                  grid_spin[r][c] = (sp < 0);
                  grid_mag -= 2 * sp;
                  grid_energy += de;
                  if (flip_tally < COUNT_CAP) flip_tally++;
               end
            end
         end
         MODE_RESCAN: begin
            // each site counts its left and upper bond once
            grid_energy = 0;
            grid_mag = 0;
            for (i = 0; i < s; i++) begin
               for (j = 0; j < s; j++) begin
                  sp = spin_val(i, j);
                  grid_mag += sp;
                  grid_energy -= sp * (spin_val(i, (j + s - 1) % s) + spin_val((i + s - 1) % s, j));
               end
            end
         end
         default: ;
      endcase
      o.accepted       = take;
      o.delta_energy   = DE_W'(de);
      o.energy         = ENERGY_W'(grid_energy);
      o.magnetization  = MAG_W'(grid_mag);
      o.accepted_count = COUNT_W'(flip_tally);
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic [LEVEL_W-1:0] pick_level();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return LEVEL_MAX;
         default: return LEVEL_W'($urandom);
      endcase
   endfunction

   // draws cluster on the thresholds so the <= edge gets hit
   function automatic logic [LEVEL_W-1:0] pick_uniform();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return LEVEL_MAX;
         2: return thresh4;
         3: return thresh4 + 1'b1;
         4: return thresh8;
         5: return thresh8 + 1'b1;
         default: return LEVEL_W'($urandom);
      endcase
   endfunction

   function automatic script_row_type op_row(mode_type m, int r, int c, bit up,
                                             logic [LEVEL_W-1:0] u, bit sw);
      script_row_type x;
      x = '0;
      x.op.mode        = m;
      x.op.row         = row_type'(r);
      x.op.col         = row_type'(c);
      x.op.spin_up     = up;
      x.op.uniform     = u;
      x.op.sweep_start = sw;
      return x;
   endfunction

   function automatic script_row_type with_outcome(script_row_type x, bit acc, int de, int e,
                                                   int m, int cnt, bit bad);
      x.typed                  = 1'b1;
      x.outcome.accepted       = acc;
      x.outcome.delta_energy   = DE_W'(de);
      x.outcome.energy         = ENERGY_W'(e);
      x.outcome.magnetization  = MAG_W'(m);
      x.outcome.accepted_count = COUNT_W'(cnt);
      x.outcome.bad_site       = bad;
      return x;
   endfunction

   function automatic script_row_type csr_row(csr_index_type sel, logic [CSR_DATA_W-1:0] val);
      script_row_type x;
      x = '0;
      x.is_csr  = 1'b1;
      x.csr_sel = sel;
      x.csr_val = val;
      return x;
   endfunction

   // present one item, hold it until taken, then queue what it must return
   task automatic send_item(trial_req_type op, bit typed, trial_rsp_type typed_outcome);
      trial_rsp_type predicted;
      if ($urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.mode        <= op.mode;
      req_chan.row         <= op.row;
      req_chan.col         <= op.col;
      req_chan.spin_up     <= op.spin_up;
      req_chan.uniform     <= op.uniform;
      req_chan.sweep_start <= op.sweep_start;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      // predictor always advances; a typed row replaces its answer
      predicted = lattice_step(op);
      trial_outcomes.push_back(typed ? typed_outcome : predicted);
      items_sent++;
      if (op.mode == MODE_TRIAL) trials_sent++;
      if (op.mode == MODE_RESCAN) rescans_sent++;
   endtask

   // every item returns a result, so an empty queue means the block is idle
   task automatic drain_outcomes();
      req_chan.valid <= 1'b0;
      while (trial_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // leaves the write enable high; the caller lowers it after its last write
   task automatic write_reg(csr_index_type sel, logic [CSR_DATA_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= sel;
      csr_wr_data <= val;
      @(posedge clock);
      case (sel)
         CSR_LATTICE_SIDE: side_setting = int'(val[SIDE_W-1:0]);
         CSR_ACCEPT_FOUR:  thresh4 = val;
         CSR_ACCEPT_EIGHT: thresh8 = val;
         default: ;
      endcase
   endtask

   task automatic set_config(int side_raw, logic [LEVEL_W-1:0] l4, logic [LEVEL_W-1:0] l8);
      drain_outcomes();
      write_reg(CSR_LATTICE_SIDE, CSR_DATA_W'(side_raw));
      write_reg(CSR_ACCEPT_FOUR, l4);
      write_reg(CSR_ACCEPT_EIGHT, l8);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // one setting, an opening rescan unless a large side skips it, then a mix dominated by legal trials
   task automatic run_phase(int count, int phase_idle);
      trial_req_type op;
      int side_raw, s, pick, k;
      logic [LEVEL_W-1:0] l4, l8;
      case ($urandom_range(0, 9))
         0: side_raw = $urandom_range(0, 1);              // clamps up to 2
         1: side_raw = $urandom_range(MAX_SIDE + 1, 127); // clamps down to MAX_SIDE
         2: side_raw = MAX_SIDE;
         default: side_raw = $urandom_range(2, SMALL_SIDE);
      endcase
      l4 = pick_level();
      // usually exp(-8/T) = exp(-4/T)^2, sometimes unrelated
      l8 = ($urandom_range(0, 3) == 0) ? pick_level() :
           LEVEL_W'((64'(l4) * 64'(l4)) >> LEVEL_W);
      set_config(side_raw, l4, l8);
      idle_pct = phase_idle;
      s = effective_side();
      op = '0;
      op.mode = MODE_RESCAN;
      if (s <= SMALL_SIDE || $urandom_range(0, 1) == 1) send_item(op, 1'b0, '0);
      for (k = 0; k < count; k++) begin
         op.mode        = MODE_TRIAL;
         op.row         = row_type'($urandom_range(0, s - 1));
         op.col         = row_type'($urandom_range(0, s - 1));
         op.spin_up     = 1'($urandom_range(0, 1));
         op.uniform     = pick_uniform();
         op.sweep_start = ($urandom_range(0, 19) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            // legal trial as set up above
         end else if (pick < 72) begin
            op.mode = MODE_WRITE;
         end else if (pick < 78 && s <= SMALL_SIDE) begin
            op.mode = MODE_RESCAN;
         end else if (pick >= 78 && pick < 88 && s < MAX_SIDE) begin
            // site past the side in use
            op.mode = ($urandom_range(0, 1) == 1) ? MODE_TRIAL : MODE_WRITE;
            if ($urandom_range(0, 1) == 1) op.row = row_type'($urandom_range(s, MAX_SIDE - 1));
            else op.col = row_type'($urandom_range(s, MAX_SIDE - 1));
         end else if (pick >= 88) begin
            // noise: all fields unconstrained, but no rescan on a large side
            op.mode        = mode_type'($urandom_range(0, 3));
            op.row         = row_type'($urandom);
            op.col         = row_type'($urandom);
            op.uniform     = LEVEL_W'($urandom);
            op.sweep_start = 1'($urandom_range(0, 1));
            if (op.mode == MODE_RESCAN && s > SMALL_SIDE) op.mode = MODE_IDLE_OP;
         end
         send_item(op, 1'b0, '0);
      end
   endtask

   task automatic note_mismatch(string what, longint got, longint want);
      mismatches++;
      $display("MISMATCH result %0d %s: got %0d, want %0d", results_seen, what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // Result side: ready is held low in random stall bursts of idle cycles
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
         stall_left <= $urandom_range(0, 2);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // compare each taken result with the oldest outstanding outcome
   always @(posedge clock) begin
      trial_rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (rsp_chan.accepted === 1'b1) flips_seen++;
         if (rsp_chan.bad_site === 1'b1) bad_seen++;
         if (trial_outcomes.size() == 0) begin
            note_mismatch("result with no item outstanding", 1, 0);
         end else begin
            want = trial_outcomes.pop_front();
            if (rsp_chan.accepted !== want.accepted)
               note_mismatch("accepted", longint'(rsp_chan.accepted),
                             longint'(want.accepted));
            if (rsp_chan.delta_energy !== want.delta_energy)
               note_mismatch("delta_energy", longint'($signed(rsp_chan.delta_energy)),
                             longint'($signed(want.delta_energy)));
            if (rsp_chan.energy !== want.energy)
               note_mismatch("energy", longint'($signed(rsp_chan.energy)),
                             longint'($signed(want.energy)));
            if (rsp_chan.magnetization !== want.magnetization)
               note_mismatch("magnetization", longint'($signed(rsp_chan.magnetization)),
                             longint'($signed(want.magnetization)));
            if (rsp_chan.accepted_count !== want.accepted_count)
               note_mismatch("accepted_count", longint'(rsp_chan.accepted_count),
                             longint'(want.accepted_count));
            if (rsp_chan.bad_site !== want.bad_site)
               note_mismatch("bad_site", longint'(rsp_chan.bad_site),
                             longint'(want.bad_site));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      script_row_type script [$];
      int i, j, n, s;

      // known values on every input from time zero
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = CSR_LATTICE_SIDE;
      csr_wr_data          = '0;
      req_chan.valid       = 1'b0;
      req_chan.mode        = MODE_WRITE;
      req_chan.row         = '0;
      req_chan.col         = '0;
      req_chan.spin_up     = 1'b0;
      req_chan.uniform     = '0;
      req_chan.sweep_start = 1'b0;
      rsp_chan.ready       = 1'b0;

      // predictor reset: all up, totals of the full-up lattice
      side_setting = RESET_SIDE;
      thresh4 = '0;
      thresh8 = '0;
      for (i = 0; i < MAX_SIDE; i++)
         for (j = 0; j < MAX_SIDE; j++)
            grid_spin[i][j] = 1'b1;
      s = effective_side();
      grid_energy = -2 * s * s;
      grid_mag = s * s;
      flip_tally = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Scripted opening at reset settings (side 64, both thresholds 0).
      // Totals after reset, mode 3 ignoring its fields
      script.push_back(with_outcome(op_row(MODE_IDLE_OP, 63, 63, 1, LEVEL_MAX, 1),
                                    0, 0, -8192, 4096, 0, 0));
      // uphill by 8, draw just above a zero threshold: rejected
      script.push_back(with_outcome(op_row(MODE_TRIAL, 0, 0, 0, 1, 0),
                                    0, 8, -8192, 4096, 0, 0));
      // draw of zero equals the zero threshold: flipped
      script.push_back(with_outcome(op_row(MODE_TRIAL, 0, 0, 0, 0, 0),
                                    1, 8, -8184, 4094, 1, 0));
      // downhill flips back whatever the draw
      script.push_back(with_outcome(op_row(MODE_TRIAL, 0, 0, 0, LEVEL_MAX, 0),
                                    1, -8, -8192, 4096, 2, 0));
      // spin write leaves totals alone
      script.push_back(with_outcome(op_row(MODE_WRITE, 63, 63, 0, 0, 0),
                                    0, 0, -8192, 4096, 2, 0));
      // sweep start clears the tally; wrapped neighbors all up so uphill, rejected
      script.push_back(with_outcome(op_row(MODE_TRIAL, 0, 0, 0, LEVEL_MAX, 1),
                                    0, 8, -8192, 4096, 0, 0));
      // rescan picks up the written corner spin
      script.push_back(with_outcome(op_row(MODE_RESCAN, 0, 0, 0, 0, 0),
                                    0, 0, -8184, 4094, 0, 0));
      // neighbor across the wrap is down: change of 4, zero draw flips
      script.push_back(with_outcome(op_row(MODE_TRIAL, 63, 0, 0, 0, 0),
                                    1, 4, -8180, 4092, 1, 0));
      script.push_back(with_outcome(op_row(MODE_WRITE, 63, 63, 1, 0, 0),
                                    0, 0, -8180, 4092, 1, 0));
      // side 0 acts as 2, both thresholds full; totals stay stale without a rescan
      script.push_back(csr_row(CSR_LATTICE_SIDE, 0));
      script.push_back(csr_row(CSR_ACCEPT_FOUR, LEVEL_MAX));
      script.push_back(csr_row(CSR_ACCEPT_EIGHT, LEVEL_MAX));
      script.push_back(op_row(MODE_TRIAL, 1, 1, 0, LEVEL_MAX, 0));
      // off-lattice trial still clears the tally
      script.push_back(with_outcome(op_row(MODE_TRIAL, 2, 0, 0, 0, 1),
                                    0, 0, -8172, 4090, 0, 1));
      script.push_back(with_outcome(op_row(MODE_WRITE, 0, 2, 0, 0, 0),
                                    0, 0, -8172, 4090, 0, 1));
      script.push_back(op_row(MODE_RESCAN, 63, 63, 1, LEVEL_MAX, 1));
      script.push_back(op_row(MODE_TRIAL, 0, 0, 1, 32'h1234_5678, 0));
      // side 127 acts as 64; thresholds mid and near zero
      script.push_back(csr_row(CSR_LATTICE_SIDE, 127));
      script.push_back(csr_row(CSR_ACCEPT_FOUR, 32'h8000_0000));
      script.push_back(csr_row(CSR_ACCEPT_EIGHT, 32'h0000_0001));
      script.push_back(op_row(MODE_RESCAN, 0, 0, 0, 0, 0));
      script.push_back(op_row(MODE_TRIAL, 63, 63, 0, 32'h8000_0000, 0));
      script.push_back(op_row(MODE_TRIAL, 63, 63, 0, 32'h8000_0001, 0));
      script.push_back(op_row(MODE_WRITE, 0, 0, 0, LEVEL_MAX, 1));
      script.push_back(op_row(MODE_TRIAL, 0, 0, 0, 32'h0000_0002, 0));
      script.push_back(op_row(MODE_TRIAL, 0, 1, 1, 32'h0000_0001, 0));
      // side 1 acts as 2
      script.push_back(csr_row(CSR_LATTICE_SIDE, 1));
      script.push_back(op_row(MODE_TRIAL, 1, 1, 1, 0, 0));
      script.push_back(op_row(MODE_IDLE_OP, 0, 0, 0, 0, 0));

      idle_pct = 20;
      foreach (script[r]) begin
         if (script[r].is_csr) begin
            drain_outcomes();
            write_reg(script[r].csr_sel, script[r].csr_val);
            csr_wr_en <= 1'b0;
            settings_used++;
         end else begin
            send_item(script[r].op, script[r].typed, script[r].outcome);
         end
      end

      // Random phases; the last three run without any idling.
      for (n = 0; n < 20; n++) begin
         run_phase($urandom_range(30, 70), (n >= 17) ? 0 : 15 * $urandom_range(0, 3));
      end

      // let everything outstanding come back, then a short quiet tail
      drain_outcomes();
      repeat (16) @(posedge clock);

      $display("covered %0d items: %0d trials, %0d flips, %0d rescans, %0d off-lattice sites",
               items_sent, trials_sent, flips_seen, rescans_sent, bad_seen);
      $display("over %0d register settings; %0d results checked, %0d mismatches",
               settings_used, results_seen, mismatches);
      if (mismatches == 0 && trial_outcomes.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin
      #3000000;
      $display("simulation failed");
      $finish;
   end

endmodule

/* sim.f */
rtl/imt_pkg.sv
rtl/imt_channels.sv
rtl/imt_ctrl.sv
rtl/imt_datapath.sv
rtl/ising_metropolis_trial_unit.sv
verif/tb_ising_metropolis_trial_unit.sv
